// ===== design/vrf_pkg.sv =====
// Shared types and constants for the video register file with vblank/NMI timing.
package vrf_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TIME  = 2'd2
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [9:0]  cpu_cycles_elapsed;
  } item_t;

  localparam int unsigned DOT_W = 17;

  localparam logic [15:0] REG_BASE = 16'h2000;
  localparam logic [15:0] REG_LAST = 16'h2007;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd2;

  localparam int unsigned STATUS_BIT = 7;

  localparam int unsigned DOTS_PER_LINE = 341;
  localparam int unsigned VBLANK_LINE   = 241;
  localparam int unsigned PRE_LINE      = 261;

  localparam logic [DOT_W-1:0] FRAME_LONG  = DOT_W'(DOTS_PER_LINE * 262);
  localparam logic [DOT_W-1:0] FRAME_SHORT = DOT_W'(DOTS_PER_LINE * 261 + 340);

  // dot 1 to dot 340 of the vblank and pre-render lines
  localparam logic [DOT_W-1:0] VBL_FIRST = DOT_W'(DOTS_PER_LINE * VBLANK_LINE + 1);
  localparam logic [DOT_W-1:0] VBL_LAST  = DOT_W'(DOTS_PER_LINE * (VBLANK_LINE + 1) - 1);
  localparam logic [DOT_W-1:0] PRE_FIRST = DOT_W'(DOTS_PER_LINE * PRE_LINE + 1);
  localparam logic [DOT_W-1:0] PRE_LAST  = DOT_W'(DOTS_PER_LINE * (PRE_LINE + 1) - 1);

endpackage

// ===== design/vrf_if.sv =====
// Request and response channel interfaces with valid/ready handshake.
interface vrf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [9:0]  cpu_cycles_elapsed;

  modport source (output valid, func, address, write_data, cpu_cycles_elapsed,
                  input ready);
  modport sink   (input valid, func, address, write_data, cpu_cycles_elapsed,
                  output ready);
endinterface

interface vrf_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        nmi_request;
  logic        vblank;
  logic [31:0] frame_count;

  modport source (output valid, read_data, nmi_request, vblank, frame_count,
                  input ready);
  modport sink   (input valid, read_data, nmi_request, vblank, frame_count,
                  output ready);
endinterface

// ===== design/vrf_input_stage.sv =====
// Input register: captures one request transfer per cycle while it is empty or the engine takes its held item.
module vrf_input_stage (
  input  logic          clk,
  input  logic          rst,
  vrf_req_if.sink       req,
  input  logic          take,
  output logic          item_valid,
  output vrf_pkg::item_t item
);
  import vrf_pkg::*;

  assign req.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.func               <= func_t'(req.func);
      item.address            <= req.address;
      item.write_data         <= req.write_data;
      item.cpu_cycles_elapsed <= req.cpu_cycles_elapsed;
    end
  end

endmodule

// ===== design/vrf_engine.sv =====
// Register file, dot counter, vblank/NMI state and the result register.
module vrf_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  vrf_pkg::item_t item,
  output logic           take,
  vrf_rsp_if.source      rsp
);
  import vrf_pkg::*;

  logic [7:0]       register_bytes [8];
  logic             nmi_flag;
  logic             nmi_enable;
  logic             nmi_line;
  logic [DOT_W-1:0] dot_count;
  logic             frame_parity;
  logic [31:0]      frames_done;

  logic [7:0]       register_bytes_next [8];
  logic             nmi_flag_next;
  logic             nmi_enable_next;
  logic             nmi_line_next;
  logic [DOT_W-1:0] dot_count_next;
  logic             frame_parity_next;
  logic [31:0]      frames_done_next;
  logic [7:0]       rd;
  logic             pulse;

  logic             hit;
  logic [2:0]       idx;
  logic [DOT_W-1:0] len;
  logic [DOT_W-1:0] sum;
  logic             in_vbl;
  logic             in_pre;

  assign take = item_valid && (!rsp.valid || rsp.ready);
  assign hit  = (item.address >= REG_BASE) && (item.address <= REG_LAST);
  assign idx  = item.address[2:0];
  assign len  = frame_parity ? FRAME_SHORT : FRAME_LONG;
  assign sum  = dot_count + {6'd0, item.cpu_cycles_elapsed, 1'b0}
                          + {7'd0, item.cpu_cycles_elapsed};

  always_comb begin
    register_bytes_next = register_bytes;
    nmi_flag_next       = nmi_flag;
    nmi_enable_next     = nmi_enable;
    nmi_line_next       = nmi_line;
    dot_count_next      = dot_count;
    frame_parity_next   = frame_parity;
    frames_done_next    = frames_done;
    rd                  = 8'd0;
    pulse               = 1'b0;
    in_vbl              = 1'b0;
    in_pre              = 1'b0;
    case (item.func)
      FUNC_READ: begin
        if (hit) begin
          if (idx == REG_STATUS) begin
            register_bytes_next[REG_STATUS][STATUS_BIT] = nmi_flag;
            nmi_flag_next = 1'b0;
          end
          rd = register_bytes_next[idx];
        end
      end
      FUNC_WRITE: begin
        if (hit) begin
          register_bytes_next[idx] = item.write_data;
          if (idx == REG_CTRL) begin
            nmi_enable_next = item.write_data[STATUS_BIT];
          end
        end
      end
      FUNC_TIME: begin
        // one wrap at most: the added dots stay well below a frame
        if (sum >= len) begin
          dot_count_next    = sum - len;
          frame_parity_next = !frame_parity;
          frames_done_next  = frames_done + 32'd1;
        end else begin
          dot_count_next = sum;
        end
        in_vbl = (dot_count_next >= VBL_FIRST) && (dot_count_next <= VBL_LAST);
        in_pre = (dot_count_next >= PRE_FIRST) && (dot_count_next <= PRE_LAST);
        if (!register_bytes[REG_STATUS][STATUS_BIT] && in_vbl) begin
          register_bytes_next[REG_STATUS][STATUS_BIT] = 1'b1;
          nmi_flag_next = 1'b1;
        end
        if (register_bytes[REG_STATUS][STATUS_BIT] && in_pre) begin
          register_bytes_next[REG_STATUS][STATUS_BIT] = 1'b0;
          nmi_flag_next = 1'b0;
        end
        nmi_line_next = nmi_flag_next && nmi_enable;
        pulse         = !nmi_line && nmi_line_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        register_bytes[i] <= 8'd0;
      end
      nmi_flag     <= 1'b0;
      nmi_enable   <= 1'b0;
      nmi_line     <= 1'b0;
      dot_count    <= '0;
      frame_parity <= 1'b0;
      frames_done  <= 32'd0;
      rsp.valid    <= 1'b0;
    end else begin
      if (take) begin
        register_bytes <= register_bytes_next;
        nmi_flag       <= nmi_flag_next;
        nmi_enable     <= nmi_enable_next;
        nmi_line       <= nmi_line_next;
        dot_count      <= dot_count_next;
        frame_parity   <= frame_parity_next;
        frames_done    <= frames_done_next;
      end
      if (!rsp.valid || rsp.ready) begin
        rsp.valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.read_data   <= rd;
      rsp.nmi_request <= pulse;
      rsp.vblank      <= register_bytes_next[REG_STATUS][STATUS_BIT];
      rsp.frame_count <= frames_done_next;
    end
  end

  a_dot_in_frame: assert property (@(posedge clk) disable iff (rst)
    dot_count < FRAME_LONG)
    else $error("dot counter beyond frame length");

  a_pulse_line_high: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.nmi_request |-> nmi_line || $past(take))
    else $error("NMI pulse without NMI line");

  a_frames_on_time_only: assert property (@(posedge clk) disable iff (rst)
    take && item.func != FUNC_TIME |=> frames_done == $past(frames_done))
    else $error("frame count moved on a bus access");

  a_pulse_time_only: assert property (@(posedge clk) disable iff (rst)
    take && item.func != FUNC_TIME |=> !rsp.nmi_request)
    else $error("NMI pulse on a bus access");

endmodule

// ===== design/video_register_file_vblank_nmi_core.sv =====
// Top level of the video register file with vblank and NMI timing.
//
// req carries bus reads, bus writes and time-advance items; rsp returns one
// result per item (read byte, NMI pulse, vblank flag, frame count).
// A transfer happens on a rising edge with valid and ready both high.
// A request is held in the input register and its result in the result
// register before the result can transfer on rsp.
// Throughput: one item per cycle while rsp does not stall; the state update
// is a three-input 17-bit add, a frame-length compare and subtract, and
// range compares on the dot count.
// When rsp stalls, the result register holds; the input register takes one
// more item only if empty, then req.ready drops until rsp drains.
// Reset (synchronous, active high) clears the registers, flags, dot count,
// frame parity and frame count, and empties both stages.
module video_register_file_vblank_nmi_core (
  input  logic      clk,
  input  logic      rst,
  vrf_req_if.sink   req,
  vrf_rsp_if.source rsp
);
  import vrf_pkg::*;

  logic  item_valid;
  item_t item;
  logic  take;

  vrf_input_stage u_input_stage (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  vrf_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .rsp        (rsp)
  );

endmodule
